// File: rtl/sem_pkg.sv
// Shared constants and types for the Sobel edge magnitude unit.
`default_nettype none
package sem_pkg;

    // Pixel and configuration widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_MIN   = 11'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd300;
    localparam logic [DIM_W-1:0] WIDTH_MAX_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX_DIM = DIM_W'(MAX_HEIGHT);

    // Line store: one entry per column holds {line r-2, line r-1}
    localparam int LINE_DEPTH = MAX_WIDTH;
    localparam int LINE_W     = 2 * PIX_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Arithmetic widths
    localparam int SUM_W    = 10;   // t + 2m + b, unsigned
    localparam int GRAD_W   = 11;   // gx, gy signed
    localparam int SQ_W     = 20;   // square of a gradient
    localparam int ENERGY_W = 21;   // gx^2 + gy^2
    localparam int ROOT_W   = 8;    // root bits before saturation
    localparam int REM_W    = 17;
    localparam int SQRT_STEPS = ROOT_W;
    localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

    // One column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

    // Clamp a dimension register to [3, hi]
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < DIM_MIN)
            res = DIM_MIN;
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sem_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/sobel_edge_magnitude_unit.sv
// Top level of the Sobel 3x3 gradient magnitude unit.
//
// Usage:
//   Pixels enter in raster order on the s_axis channel, one per transaction.
//   For every interior pixel one result leaves on m_axis: tdata is
//   floor(sqrt(gx^2 + gy^2)) saturated at 255, tlast marks the last interior
//   pixel of the frame. Border pixels give no result.
//   The cfg channel writes image_width (index 0) and image_height (index 1);
//   values are clamped to 3..1024. cfg_ready is always high; write only
//   while no pixel is in flight.
//   Throughput: one pixel per clock outside stalls and the clearing pass.
//   The line store is one 1024 x 16 RAM, read at accept and written back from stage 1;
//   a column address repeats no sooner than three pixels apart, so no forwarding is needed.
//   Pipeline: a result shows on m_axis_tvalid after the pixel that completes
//   its window is accepted and passes the RAM read, window, gradients, squares,
//   sum, eight root stages and output register.
//   Reset: counters clear, registers go to 300 x 300, and the line store is
//   zeroed in a pass over all 1024 entries during which s_axis_tready stays low.
//   Stall: when m_axis_tready is low with a result waiting, the whole
//   pipeline holds and s_axis_tready drops until the result is taken.
`default_nettype none
module sobel_edge_magnitude_unit
    import sem_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // pixel input; tdata[7:0] = pixel
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [PIX_W-1:0]     s_axis_tdata,
    // result output; tdata[7:0] = magnitude
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [PIX_W-1:0]     m_axis_tdata,
    output logic                      m_axis_tlast,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    // Configuration registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // Counters and clearing pass
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             clr_active_reg;
    logic [COL_W-1:0] clr_addr_reg;

    // Pipeline control
    logic en;
    logic accept;
    logic produce;
    logic is_last;

    // Stage 1: RAM read in flight
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_prod_reg;
    logic             s1_last_reg;

    // Line store
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_rdata;

    // Stage 2: window
    win_col_t col0_reg;
    win_col_t col1_reg;
    win_col_t col2_reg;
    logic     s2_valid_reg;
    logic     s2_last_reg;

    // Stage 3: gradients
    logic [SUM_W-1:0]         gx_pos;
    logic [SUM_W-1:0]         gx_neg;
    logic [SUM_W-1:0]         gy_pos;
    logic [SUM_W-1:0]         gy_neg;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic                     s3_valid_reg;
    logic                     s3_last_reg;

    // Stage 4: squares
    logic signed [2*GRAD_W-1:0] gx_prod;
    logic signed [2*GRAD_W-1:0] gy_prod;
    logic [SQ_W-1:0]            gx_sq_reg;
    logic [SQ_W-1:0]            gy_sq_reg;
    logic                       s4_valid_reg;
    logic                       s4_last_reg;
    logic [ENERGY_W-1:0]        energy;

    // Root pipeline, entry 0 is the energy stage
    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS+1];
    logic              sat_reg  [SQRT_STEPS+1];
    logic              rv_reg   [SQRT_STEPS+1];
    logic              rl_reg   [SQRT_STEPS+1];
    logic [REM_W-1:0]  trial    [SQRT_STEPS];
    logic              take     [SQRT_STEPS];

    // Output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_mag_reg;
    logic             out_last_reg;

    assign cfg_ready = 1'b1;
    assign w_eff = clamp_dim(width_reg, WIDTH_MAX_DIM);
    assign h_eff = clamp_dim(height_reg, HEIGHT_MAX_DIM);

    // Whole pipeline moves unless a result waits on a stalled receiver
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en && !clr_active_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Interior test and frame end on the current counters
    always_comb
    begin
        produce = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
                  && ({1'b0, row_reg} < h_eff) && ({1'b0, col_reg} < w_eff);
        is_last = ({1'b0, row_reg} == h_eff - DIM_W'(1))
                  && ({1'b0, col_reg} == w_eff - DIM_W'(1));
    end

    // Counter advance with wrap at line and frame end
    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (({1'b0, col_reg} + DIM_W'(1)) >= w_eff)
        begin
            col_next = '0;
            if (({1'b0, row_reg} + DIM_W'(1)) >= h_eff)
                row_next = '0;
            else
                row_next = row_reg + ROW_W'(1);
        end
    end

    // Configuration, counters and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= DIM_RESET;
            height_reg     <= DIM_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(LINE_DEPTH - 1))
                    clr_active_reg <= 1'b0;
            end
        end
    end

    // Line store write: zeros during the pass, else shift lines at this column
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = en && s1_valid_reg;
            ram_waddr = s1_col_reg;
            ram_wdata = {ram_rdata[PIX_W-1:0], s1_px_reg};
        end
    end

    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= SQRT_STEPS; i++)
            begin
                rv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && s1_prod_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            rv_reg[0]     <= s4_valid_reg;
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                rv_reg[i+1] <= rv_reg[i];
            end
            out_valid_reg <= rv_reg[SQRT_STEPS];
        end
    end

    // Gradient sums from the window; column 0 is the oldest
    always_comb
    begin
        gx_pos = SUM_W'(col2_reg.top) + {1'b0, col2_reg.mid, 1'b0} + SUM_W'(col2_reg.bot);
        gx_neg = SUM_W'(col0_reg.top) + {1'b0, col0_reg.mid, 1'b0} + SUM_W'(col0_reg.bot);
        gy_pos = SUM_W'(col0_reg.bot) + {1'b0, col1_reg.bot, 1'b0} + SUM_W'(col2_reg.bot);
        gy_neg = SUM_W'(col0_reg.top) + {1'b0, col1_reg.top, 1'b0} + SUM_W'(col2_reg.top);
        gx_prod = gx_reg * gx_reg;
        gy_prod = gy_reg * gy_reg;
        energy  = ENERGY_W'(gx_sq_reg) + ENERGY_W'(gy_sq_reg);
    end

    // One root bit per stage: test (2R + 2^b) * 2^b against the remainder
    always_comb
    begin
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            trial[i] = (REM_W'(root_reg[i]) << (ROOT_W - i))
                       + (REM_W'(1) << (2 * (ROOT_W - 1 - i)));
            take[i]  = rem_reg[i] >= trial[i];
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                s1_px_reg   <= s_axis_tdata;
                s1_col_reg  <= col_reg;
                s1_prod_reg <= produce;
                s1_last_reg <= is_last;
            end
            if (s1_valid_reg)
            begin
                col0_reg     <= col1_reg;
                col1_reg     <= col2_reg;
                col2_reg.top <= ram_rdata[LINE_W-1:PIX_W];
                col2_reg.mid <= ram_rdata[PIX_W-1:0];
                col2_reg.bot <= s1_px_reg;
            end
            s2_last_reg <= s1_last_reg;

            gx_reg      <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
            gy_reg      <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
            s3_last_reg <= s2_last_reg;

            gx_sq_reg   <= gx_prod[SQ_W-1:0];
            gy_sq_reg   <= gy_prod[SQ_W-1:0];
            s4_last_reg <= s3_last_reg;

            rem_reg[0]  <= REM_W'(energy[2*ROOT_W-1:0]);
            root_reg[0] <= '0;
            sat_reg[0]  <= |energy[ENERGY_W-1:2*ROOT_W];
            rl_reg[0]   <= s4_last_reg;

            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                rem_reg[i+1]  <= take[i] ? (rem_reg[i] - trial[i]) : rem_reg[i];
                root_reg[i+1] <= take[i] ? (root_reg[i] | (ROOT_W'(1) << (ROOT_W - 1 - i)))
                                         : root_reg[i];
                sat_reg[i+1]  <= sat_reg[i];
                rl_reg[i+1]   <= rl_reg[i];
            end

            out_mag_reg  <= sat_reg[SQRT_STEPS] ? MAG_SAT : root_reg[SQRT_STEPS];
            out_last_reg <= rl_reg[SQRT_STEPS];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_mag_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire
